/* rtl/qsg_pkg.sv */
// Shared types, opcodes, pose tables and waveform functions for the
// quadruped servo gait generator. No dependencies.
`default_nettype none
package qsg_pkg;

  localparam int NumLegs  = 4;
  localparam int PosW     = 12;
  localparam int PhaseW   = 7;
  localparam int SlewW    = 8;
  localparam int OpW      = 4;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;

  localparam logic [PhaseW-1:0] PhaseSteps = 7'd100;
  localparam logic [PosW-1:0]   MidPos     = 12'd750;
  localparam logic [PosW-1:0]   InvertBase = 12'd1500;

  // Opcodes
  localparam logic [OpW-1:0] OP_HOLD   = 4'd0;
  localparam logic [OpW-1:0] OP_FWD    = 4'd1;
  localparam logic [OpW-1:0] OP_BACK   = 4'd2;
  localparam logic [OpW-1:0] OP_LEFT   = 4'd3;
  localparam logic [OpW-1:0] OP_RIGHT  = 4'd4;
  localparam logic [OpW-1:0] OP_DANCE  = 4'd5;
  localparam logic [OpW-1:0] OP_SIT    = 4'd6;
  localparam logic [OpW-1:0] OP_SLEEP  = 4'd7;
  localparam logic [OpW-1:0] OP_CENTRE = 4'd8;
  localparam logic [OpW-1:0] OP_SET    = 4'd9;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_GAIT_SLEW    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_POSE_SLEW    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INVERT_MASK  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PHASE_LAG    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_POSITION = 3'd4;

  typedef logic [NumLegs-1:0][PosW-1:0] leg_vec_t;

  typedef struct packed {
    logic [SlewW-1:0]   gait_slew;
    logic [SlewW-1:0]   pose_slew;
    logic [NumLegs-1:0] invert_mask;
    logic [PhaseW-1:0]  phase_lag;
    logic [PosW-1:0]    max_position;
  } cfg_t;

  // Legs ordered front left, front right, rear left, rear right.
  localparam leg_vec_t SitPose   = {12'd250, 12'd1250, 12'd750,  12'd750};
  localparam leg_vec_t SleepPose = {12'd250, 12'd1250, 12'd1250, 12'd250};

  // Sum of a phase and an offset below 100, wrapped into 0..99.
  function automatic logic [PhaseW-1:0] add_mod100(input logic [PhaseW-1:0] t,
                                                   input logic [PhaseW-1:0] k);
    logic [PhaseW:0] s;
    s = {1'b0, t} + {1'b0, k};
    return (s >= {1'b0, PhaseSteps}) ? PhaseW'(s - {1'b0, PhaseSteps}) : s[PhaseW-1:0];
  endfunction

  // Fast drop from 1050 to 450 over ten steps, then a slow climb back.
  function automatic logic [PosW-1:0] wave_fwd(input logic [PhaseW-1:0] t);
    logic [PosW-1:0] tw;
    tw = PosW'(t);
    return (t < 7'd10) ? (12'd1050 - tw * 12'd60) : (12'd450 + (tw - 12'd10) * 12'd6);
  endfunction

  function automatic logic [PosW-1:0] wave_back(input logic [PhaseW-1:0] t);
    logic [PosW-1:0] tw;
    tw = PosW'(t);
    return (t < 7'd10) ? (12'd450 + tw * 12'd60) : (12'd1050 - (tw - 12'd10) * 12'd6);
  endfunction

endpackage
`default_nettype wire

/* rtl/quad_servo_gait_generator.sv */
// Top level of the quadruped servo gait generator: input and result
// registers, leg and phase state, configuration. Uses qsg_pkg, qsg_target, qsg_slew.
`default_nettype none
// Usage:
// Each word on the s_ channel is one control tick carrying an opcode, a leg
// channel and a position value. Every accepted tick produces exactly one word
// on the m_ channel holding the four leg compare values, the gait phase and
// the pose-done flag, all as they stand after that tick.
// Configuration registers (slews, invert mask, phase lag, position clamp) are written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no tick is in
// flight, as the block does not enforce it; indexes above the last register are ignored.
// A tick accepted into the input register moves on to the result register once
// that register is empty or its word is being taken; its word is then offered on m_.
// Throughput: one tick per cycle while the receiver takes every word; the whole
// update is one pass of logic between the input register and the result register,
// with the leg state updated at the same edge the result is loaded.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more tick; after that s_tready falls until the
// result is taken.
// Reset puts every leg at 750, the phase at 0 and all registers at their
// default values, and empties both stages.
module quad_servo_gait_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[3:0], channel[5:4], value[17:6], zero pad[23:18]
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // pos_front_left[11:0], pos_front_right[23:12], pos_rear_left[35:24],
  // pos_rear_right[47:36], phase[54:48], pose_done[55]
  output logic [55:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic [qsg_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [qsg_pkg::CfgDataW-1:0] cfg_data
);
  import qsg_pkg::*;

  cfg_t cfg;

  // Input stage
  logic              in_valid;
  logic [OpW-1:0]    in_opcode;
  logic [1:0]        in_channel;
  logic [PosW-1:0]   in_value;

  // Kept state
  leg_vec_t          leg_position;
  logic [PhaseW-1:0] gait_phase;

  leg_vec_t          leg_position_next;
  logic [PhaseW-1:0] gait_phase_next;
  logic              pose_done_next;

  leg_vec_t           target;
  logic [SlewW-1:0]   step;
  leg_vec_t           slewed;
  logic [NumLegs-1:0] off_target;
  logic               is_gait;
  logic               is_pose;
  logic [PosW-1:0]    set_value;
  logic               advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gait_slew    <= 8'd30;
      cfg.pose_slew    <= 8'd10;
      cfg.invert_mask  <= 4'd10;
      cfg.phase_lag    <= 7'd50;
      cfg.max_position <= 12'd2500;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAIT_SLEW:    cfg.gait_slew    <= cfg_data[SlewW-1:0];
        REG_POSE_SLEW:    cfg.pose_slew    <= cfg_data[SlewW-1:0];
        REG_INVERT_MASK:  cfg.invert_mask  <= cfg_data[NumLegs-1:0];
        REG_PHASE_LAG:    cfg.phase_lag    <= cfg_data[PhaseW-1:0];
        REG_MAX_POSITION: cfg.max_position <= cfg_data[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: takes a new tick whenever it is empty or its content moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode  <= s_tdata[3:0];
      in_channel <= s_tdata[5:4];
      in_value   <= s_tdata[17:6];
    end
  end

  qsg_target u_target (
    .opcode (in_opcode),
    .phase  (gait_phase),
    .cfg    (cfg),
    .target (target),
    .step   (step)
  );

  for (genvar g = 0; g < NumLegs; g++) begin : g_leg
    qsg_slew u_slew (
      .cur        (leg_position[g]),
      .target     (target[g]),
      .step       (step),
      .pos_next   (slewed[g]),
      .off_target (off_target[g])
    );
  end

  always_comb begin
    is_gait   = (in_opcode >= OP_FWD) && (in_opcode <= OP_DANCE);
    is_pose   = (in_opcode == OP_SIT) || (in_opcode == OP_SLEEP);
    set_value = (in_value > cfg.max_position) ? cfg.max_position : in_value;

    leg_position_next = leg_position;
    gait_phase_next   = gait_phase;
    pose_done_next    = 1'b0;

    if (is_gait) begin
      leg_position_next = slewed;
      gait_phase_next   = (gait_phase == PhaseSteps - 7'd1) ? '0 : gait_phase + 7'd1;
    end else if (is_pose) begin
      leg_position_next = slewed;
      pose_done_next    = (off_target == '0);
    end else if (in_opcode == OP_CENTRE) begin
      leg_position_next = {NumLegs{MidPos}};
    end else if (in_opcode == OP_SET) begin
      leg_position_next[in_channel] = set_value;
    end
  end

  // State and result register load together when a tick moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      leg_position <= {NumLegs{MidPos}};
      gait_phase   <= '0;
      m_tvalid     <= 1'b0;
    end else if (advance) begin
      leg_position <= leg_position_next;
      gait_phase   <= gait_phase_next;
      m_tvalid     <= 1'b1;
    end else if (m_tready) begin
      m_tvalid     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {pose_done_next, gait_phase_next, leg_position_next[3],
                  leg_position_next[2], leg_position_next[1], leg_position_next[0]};
    end
  end

endmodule
`default_nettype wire

/* rtl/qsg_target.sv */
// Target selection: per-leg gait waveform targets or fixed pose targets,
// and the slew step for the current opcode. Uses qsg_pkg.
`default_nettype none
module qsg_target (
  input  wire logic [qsg_pkg::OpW-1:0]    opcode,
  input  wire logic [qsg_pkg::PhaseW-1:0] phase,
  input  wire qsg_pkg::cfg_t              cfg,
  output qsg_pkg::leg_vec_t               target,
  output logic [qsg_pkg::SlewW-1:0]       step
);
  import qsg_pkg::*;

  logic [PhaseW-1:0]              lag_mod;
  logic [PhaseW-1:0]              phase_b;
  logic [NumLegs-1:0][PhaseW-1:0] leg_t;
  logic [NumLegs-1:0]             leg_back;
  logic [NumLegs-1:0][PosW-1:0]   wave;

  always_comb begin
    lag_mod = (cfg.phase_lag >= PhaseSteps) ? (cfg.phase_lag - PhaseSteps) : cfg.phase_lag;
    phase_b = (phase >= lag_mod) ? (phase - lag_mod) : (phase + PhaseSteps - lag_mod);
  end

  // Time base and waveform direction of each leg.
  always_comb begin
    leg_t = {phase, phase_b, phase_b, phase};
    case (opcode)
      OP_FWD:   leg_back = 4'b0000;
      OP_BACK:  leg_back = 4'b1111;
      OP_LEFT:  leg_back = 4'b0101;
      OP_RIGHT: leg_back = 4'b1010;
      OP_DANCE: begin
        leg_back = 4'b1100;
        leg_t = {add_mod100(phase, 7'd75), add_mod100(phase, 7'd50),
                 add_mod100(phase, 7'd25), phase};
      end
      default:  leg_back = 4'b0000;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NumLegs; i++) begin
      wave[i] = leg_back[i] ? wave_back(leg_t[i]) : wave_fwd(leg_t[i]);
      if (cfg.invert_mask[i]) begin
        wave[i] = InvertBase - wave[i];
      end
    end
  end

  always_comb begin
    case (opcode)
      OP_SIT: begin
        target = SitPose;
        step   = cfg.pose_slew;
      end
      OP_SLEEP: begin
        target = SleepPose;
        step   = cfg.pose_slew;
      end
      default: begin
        target = wave;
        step   = cfg.gait_slew;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/qsg_slew.sv */
// One leg's slew limiter: moves a position toward its target by at most
// one step without overshoot. Uses qsg_pkg.
`default_nettype none
module qsg_slew (
  input  wire logic [qsg_pkg::PosW-1:0]  cur,
  input  wire logic [qsg_pkg::PosW-1:0]  target,
  input  wire logic [qsg_pkg::SlewW-1:0] step,
  output logic [qsg_pkg::PosW-1:0]       pos_next,
  output logic                           off_target
);
  import qsg_pkg::*;

  logic [PosW:0]   up;
  logic [PosW-1:0] diff;

  always_comb begin
    up         = {1'b0, cur} + (PosW+1)'(step);
    diff       = cur - target;
    off_target = (cur != target);
    if (cur < target) begin
      pos_next = (up > {1'b0, target}) ? target : up[PosW-1:0];
    end else if (cur > target) begin
      pos_next = (diff > PosW'(step)) ? (cur - PosW'(step)) : target;
    end else begin
      pos_next = cur;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb_quad_servo_gait_generator.sv */
// Self-checking bench for quad_servo_gait_generator: streams control ticks,
// predicts every result word and checks it field by field.
// Depends on rtl/qsg_pkg.sv, rtl/quad_servo_gait_generator.sv and the modules it uses.
module tb_quad_servo_gait_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import qsg_pkg::*;

  // Percent of cycles in which either side idles, outside the steady phase.
  localparam int IdlePct      = 14;
  // Cycles with no handshake on either side before the run is abandoned.
  localparam int StallLimit   = 2000;
  // Margin waited once every result is back, before the registers are written again.
  localparam int SettleCycles = 4;
  localparam int ReportLimit  = 10;
  localparam int ResetCycles  = 7;

  // Opcodes the block does not define; they must behave as hold.
  localparam logic [OpW-1:0] OpSpareLo = 4'd10;
  localparam logic [OpW-1:0] OpSpareHi = 4'd15;

  // Pose tables, leg 0 (front left) in the lowest slot.
  localparam logic [NumLegs-1:0][PosW-1:0] SitLegs   = {12'd250, 12'd1250, 12'd750, 12'd750};
  localparam logic [NumLegs-1:0][PosW-1:0] SleepLegs = {12'd250, 12'd1250, 12'd1250, 12'd250};

  // One result word, laid out exactly as m_tdata: legs from bit 0, then phase,
  // then the pose flag at the top.
  typedef struct packed {
    logic                         pose_done;
    logic [PhaseW-1:0]            phase;
    logic [NumLegs-1:0][PosW-1:0] leg;
  } servo_frame_t;

  logic clk;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // opcode[3:0], channel[5:4], value[17:6], zero pad[23:18]
  logic [23:0]         s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // pos_front_left[11:0], pos_front_right[23:12], pos_rear_left[35:24],
  // pos_rear_right[47:36], phase[54:48], pose_done[55]
  logic [55:0]         m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  quad_servo_gait_generator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted leg state and phase, plus the register copies that steer them.
  logic [NumLegs-1:0][PosW-1:0] leg_now;
  logic [PhaseW-1:0]            phase_now;
  logic [SlewW-1:0]             walk_step;
  logic [SlewW-1:0]             pose_step;
  logic [NumLegs-1:0]           flip_legs;
  logic [PhaseW-1:0]            pair_trail;
  logic [PosW-1:0]              set_ceiling;

  // Ticks waiting for the driver, and result words owed by the block.
  logic [23:0]  tick_q[$];
  servo_frame_t frames_due[$];
  servo_frame_t seen_frame;

  // When set, neither side idles, giving one long back-to-back stretch.
  bit steady = 1'b0;

  int mismatches   = 0;
  int ticks_in     = 0;
  int words_out    = 0;
  int gait_ticks   = 0;
  int pose_ticks   = 0;
  int poses_held   = 0;
  int set_ticks    = 0;
  int settings_run = 0;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One leg stroke over a 100-step cycle. The forward stroke drops fast from
  // 1050 to 450 over the first ten steps and climbs back slowly; the reverse
  // stroke is its mirror about 750.
  function automatic int stroke(input bit reverse, input int t);
    int u;
    u = t % 100;
    if (reverse) return (u < 10) ? 450 + 60 * u : 1050 - 6 * (u - 10);
    return (u < 10) ? 1050 - 60 * u : 450 + 6 * (u - 10);
  endfunction

  // A leg mounted the other way round sees its stroke mirrored about 750.
  function automatic int leg_aim(input int leg, input bit reverse, input int t);
    int v;
    v = stroke(reverse, t);
    return flip_legs[leg] ? 1500 - v : v;
  endfunction

  // Moves one leg toward its aim by at most step, landing exactly on the aim
  // rather than passing it. Returns 1 when the leg started off its aim.
  function automatic bit nudge_leg(input int leg, input int aim, input int step);
    int cur;
    cur = int'(leg_now[leg]);
    if (cur == aim) return 1'b0;
    if (cur < aim) cur = (cur + step > aim) ? aim : cur + step;
    else cur = (cur - aim > step) ? cur - step : aim;
    leg_now[leg] = PosW'(cur);
    return 1'b1;
  endfunction

  // Applies one tick to the predicted state and returns the word it must yield.
  function automatic servo_frame_t advance_tick(input logic [23:0] word);
    logic [OpW-1:0]  op;
    logic [1:0]      ch;
    logic [PosW-1:0] val;
    int              ta;
    int              tb;
    int              aim [NumLegs];
    bit              left_rev;
    bit              right_rev;
    bit              moved;
    servo_frame_t    res;
    op    = word[3:0];
    ch    = word[5:4];
    val   = word[17:6];
    moved = 1'b0;
    res.pose_done = 1'b0;
    ta = int'(phase_now);
    // The front right / rear left pair trails by the lag, taken modulo 100.
    tb = (ta + 200 - (int'(pair_trail) % 100)) % 100;
    case (op)
      OP_FWD, OP_BACK, OP_LEFT, OP_RIGHT, OP_DANCE: begin
        if (op == OP_DANCE) begin
          // Dance spreads the legs a quarter cycle apart and ignores the lag;
          // the rear pair runs the reverse stroke.
          for (int i = 0; i < NumLegs; i++) aim[i] = leg_aim(i, i >= 2, ta + 25 * i);
        end else begin
          // Left legs reverse when backing up or turning left, right legs when
          // backing up or turning right.
          left_rev  = (op == OP_BACK) || (op == OP_LEFT);
          right_rev = (op == OP_BACK) || (op == OP_RIGHT);
          aim[0] = leg_aim(0, left_rev, ta);
          aim[1] = leg_aim(1, right_rev, tb);
          aim[2] = leg_aim(2, left_rev, tb);
          aim[3] = leg_aim(3, right_rev, ta);
        end
        for (int i = 0; i < NumLegs; i++) moved |= nudge_leg(i, aim[i], int'(walk_step));
        phase_now = PhaseW'((ta + 1) % 100);
      end
      OP_SIT, OP_SLEEP: begin
        for (int i = 0; i < NumLegs; i++)
          moved |= nudge_leg(i, (op == OP_SIT) ? int'(SitLegs[i]) : int'(SleepLegs[i]),
                             int'(pose_step));
        res.pose_done = !moved;
      end
      OP_CENTRE: begin
        for (int i = 0; i < NumLegs; i++) leg_now[i] = MidPos;
      end
      OP_SET: begin
        leg_now[ch] = (val > set_ceiling) ? set_ceiling : val;
      end
      default: begin
      end
    endcase
    res.leg   = leg_now;
    res.phase = phase_now;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_miss(input string what, input logic [PosW-1:0] want,
                             input logic [PosW-1:0] got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("word %0d: %s expected %0d, got %0d", words_out, what, want, got);
  endtask

  task automatic compare_frame(input servo_frame_t want, input servo_frame_t got);
    for (int i = 0; i < NumLegs; i++)
      if (got.leg[i] !== want.leg[i])
        report_miss($sformatf("leg %0d position", i), want.leg[i], got.leg[i]);
    if (got.phase !== want.phase)
      report_miss("phase", PosW'(want.phase), PosW'(got.phase));
    if (got.pose_done !== want.pose_done)
      report_miss("pose_done", PosW'(want.pose_done), PosW'(got.pose_done));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued ticks, holds a word until it is taken, and predicts
  // each tick at the edge where it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        frames_due.push_back(advance_tick(s_tdata));
        ticks_in++;
        case (s_tdata[3:0])
          OP_FWD, OP_BACK, OP_LEFT, OP_RIGHT, OP_DANCE: gait_ticks++;
          OP_SIT, OP_SLEEP: pose_ticks++;
          OP_SET: set_ticks++;
          default: begin
          end
        endcase
      end
      // A new word goes out only once the current one is gone; random gaps
      // are inserted here unless the steady stretch is running.
      if (!s_tvalid || s_tready) begin
        if (tick_q.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= tick_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes result words under random back-pressure and checks each one
  // against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_frame = servo_frame_t'(m_tdata);
        words_out++;
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("word %0d arrived with no tick outstanding: %h", words_out, m_tdata);
        end else begin
          compare_frame(frames_due.pop_front(), seen_frame);
        end
        if (seen_frame.pose_done === 1'b1) poses_held++;
      end
      m_tready <= steady || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // Watchdog: a run that stops moving on both sides is a failure.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("No handshake for %0d cycles; %0d ticks sent, %0d words seen.",
               stall_cycles, ticks_in, words_out);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Writes one register and mirrors it into the predictor.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataW'(data);
    case (idx)
      REG_GAIT_SLEW:    walk_step   = SlewW'(data);
      REG_POSE_SLEW:    pose_step   = SlewW'(data);
      REG_INVERT_MASK:  flip_legs   = NumLegs'(data);
      REG_PHASE_LAG:    pair_trail  = PhaseW'(data);
      REG_MAX_POSITION: set_ceiling = PosW'(data);
      default: begin
      end
    endcase
  endtask

  // Loads a full register setting. Only called with the block drained.
  task automatic program_regs(input int gait, input int pose, input int flips,
                              input int lag, input int ceiling);
    write_reg(REG_GAIT_SLEW, gait);
    write_reg(REG_POSE_SLEW, pose);
    write_reg(REG_INVERT_MASK, flips);
    write_reg(REG_PHASE_LAG, lag);
    write_reg(REG_MAX_POSITION, ceiling);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
    @(negedge clk);
  endtask

  // Waits until every tick has been sent and every result has come back.
  task automatic settle();
    do @(negedge clk); while (tick_q.size() != 0 || s_tvalid || frames_due.size() != 0);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic push_exact(input logic [OpW-1:0] op, input logic [1:0] ch,
                            input logic [PosW-1:0] val);
    tick_q.push_back({6'b0, val, ch, op});
  endtask

  // Queues a tick with random channel and value. Values lean toward the ends
  // of the field and the edges of the current clamp.
  task automatic push_tick(input logic [OpW-1:0] op);
    logic [PosW-1:0] val;
    case ($urandom_range(0, 7))
      0: val = '0;
      1: val = '1;
      2: val = set_ceiling;
      3: val = set_ceiling + 1'b1;
      default: val = PosW'($urandom);
    endcase
    push_exact(op, 2'($urandom), val);
  endtask

  // Random traffic made mostly of realistic runs: a gait held long enough to
  // walk through much of the cycle, a pose held for a run of ticks, a few direct
  // sets. About one tick in twenty inside a run is a random opcode, which
  // breaks the run the way a stray command would.
  task automatic queue_burst(input int count);
    int             left;
    int             run;
    int             pick;
    logic [OpW-1:0] op;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        op  = OpW'($urandom_range(OP_FWD, OP_DANCE));
        run = $urandom_range(5, 110);
      end else if (pick < 75) begin
        op  = $urandom_range(0, 1) ? OP_SIT : OP_SLEEP;
        run = $urandom_range(3, 60);
      end else if (pick < 87) begin
        op  = OP_SET;
        run = $urandom_range(1, 4);
      end else if (pick < 92) begin
        op  = OP_CENTRE;
        run = 1;
      end else if (pick < 97) begin
        op  = OP_HOLD;
        run = $urandom_range(1, 3);
      end else begin
        op  = OpW'($urandom_range(OpSpareLo, OpSpareHi));
        run = $urandom_range(1, 2);
      end
      if (run > left) run = left;
      repeat (run) begin
        if ($urandom_range(0, 99) < 5) push_tick(OpW'($urandom_range(0, 15)));
        else push_tick(op);
      end
      left -= run;
    end
  endtask

  initial begin
    // Predictor starts where the block comes out of reset.
    for (int i = 0; i < NumLegs; i++) leg_now[i] = MidPos;
    phase_now   = '0;
    walk_step   = 8'd30;
    pose_step   = 8'd10;
    flip_legs   = 4'd10;
    pair_trail  = 7'd50;
    set_ceiling = 12'd2500;

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed ticks under the reset values of the registers.
    push_exact(OP_HOLD, 2'd0, 12'd0);
    // Direct sets: above the clamp, at zero, at the clamp, one past it.
    push_exact(OP_SET, 2'd0, 12'd4095);
    push_exact(OP_SET, 2'd1, 12'd0);
    push_exact(OP_SET, 2'd2, 12'd2500);
    push_exact(OP_SET, 2'd3, 12'd2501);
    // One tick of every gait; channel and value must be ignored.
    push_exact(OP_FWD, 2'd3, 12'd4095);
    push_exact(OP_BACK, 2'd0, 12'd0);
    push_exact(OP_LEFT, 2'd1, 12'd1234);
    push_exact(OP_RIGHT, 2'd2, 12'd2048);
    push_exact(OP_DANCE, 2'd3, 12'd7);
    push_exact(OP_CENTRE, 2'd0, 12'd4095);
    // A sleep tick from centre moves legs, so it must not report done.
    push_exact(OP_SLEEP, 2'd0, 12'd0);
    // Place the legs on the sit pose by hand; sit must then report done.
    push_exact(OP_SET, 2'd0, 12'd750);
    push_exact(OP_SET, 2'd1, 12'd750);
    push_exact(OP_SET, 2'd2, 12'd1250);
    push_exact(OP_SET, 2'd3, 12'd250);
    push_exact(OP_SIT, 2'd0, 12'd0);
    push_exact(OP_SIT, 2'd3, 12'd4095);
    // Same for the sleep pose, which differs only in the front legs.
    push_exact(OP_SET, 2'd0, 12'd250);
    push_exact(OP_SET, 2'd1, 12'd1250);
    push_exact(OP_SLEEP, 2'd1, 12'd0);
    // Undefined opcodes must act as hold.
    push_exact(OpSpareLo, 2'd3, 12'd4095);
    push_exact(OpSpareHi, 2'd3, 12'd4095);
    settle();

    // Zero slews: gaits and poses hold every leg, and a pose off target never
    // reports done. A zero clamp pins every direct set to zero.
    program_regs(0, 0, 0, 0, 0);
    queue_burst(120);
    settle();

    // Largest values: every leg mirrored, a lag past 99 that must wrap, no
    // effective clamp on direct sets.
    program_regs(255, 255, 15, 127, 4095);
    queue_burst(250);
    settle();

    // Unit slews and the largest in-range lag.
    program_regs(1, 1, 5, 99, 1);
    queue_burst(250);
    settle();

    // Reset values again, run back to back with no idling on either side.
    program_regs(30, 10, 10, 50, 2500);
    steady = 1'b1;
    queue_burst(250);
    settle();
    steady = 1'b0;

    // A lag of exactly 100 behaves as no lag.
    program_regs(60, 40, 9, 100, 1500);
    queue_burst(250);
    settle();

    repeat (2) begin
      program_regs($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(0, 15),
                   $urandom_range(0, 127), $urandom_range(0, 4095));
      queue_burst(250);
      settle();
    end

    program_regs(7, 3, 6, 25, 4094);
    queue_burst(250);
    settle();

    $display("Sent %0d ticks under %0d register settings: %0d gait, %0d pose, %0d direct set.",
             ticks_in, settings_run + 1, gait_ticks, pose_ticks, set_ticks);
    $display("Checked %0d result words; %0d showed a settled pose; %0d field mismatches.",
             words_out, poses_held, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/qsg_pkg.sv
rtl/qsg_target.sv
rtl/qsg_slew.sv
rtl/quad_servo_gait_generator.sv
tb/sv/tb_quad_servo_gait_generator.sv
